FILE: rtl/leb_pkg.sv
// leb_pkg: shared sizes, configuration register indexes and the op type for the
// line edit buffer. No dependencies; every other file refers to it by scoped names.
package leb_pkg;

  localparam int LINE_DEPTH  = 64;
  localparam int IDX_W       = $clog2(LINE_DEPTH);
  localparam int CNT_W       = $clog2(LINE_DEPTH + 1);
  localparam int CHAR_W      = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_W       = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_ERASE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_KILL  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_END   = CFG_IDX_W'(2);

  localparam logic [CHAR_W-1:0] ERASE_RST = CHAR_W'(35);
  localparam logic [CHAR_W-1:0] KILL_RST  = CHAR_W'(64);
  localparam logic [CHAR_W-1:0] END_RST   = CHAR_W'(10);

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_ERASE  = 2'd1,
    OP_KILL   = 2'd2,
    OP_FLUSH  = 2'd3
  } op_kind_e;

  typedef struct packed {
    op_kind_e          kind;
    logic [CHAR_W-1:0] ch;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

FILE: rtl/line_edit_buffer_core.sv
// line_edit_buffer_core: line editor with erase and kill characters.
// Uses leb_front, leb_queue and leb_back; depends on leb_pkg.
//
// Input channel (in_valid_i / in_stall_o): one character or end-of-input mark
// per transaction. Output channel (out_valid_o / out_stall_i): one character of
// an edited line per transaction, oldest first, last_of_line_o on the final one
// and truncated_o on it when characters were dropped because the 64-entry line
// store was full. Line ends and empty lines produce no output.
// Configuration: cfg_we_i writes erase (0), kill (1) or end (2) code; other
// indexes are ignored. Write only while the block is idle.
// Throughput: one character per cycle while editing. A line flush of n stored
// characters keeps the back end busy reading them through the one line store
// read port; meanwhile the two-entry op queue keeps taking input until it fills.
// A flushed line's characters pass from the line end's op pop through the store
// read and the output register, one per cycle while the receiver does not stall.
// Reset clears the line, the queue and the output valid flag, and loads
// the default codes ('#', '@', line feed); no clearing pass is needed.
// A stalled receiver holds the output register; the store read stage behind it
// fills, then the drain pauses, then the queue fills and in_stall_o rises.
module line_edit_buffer_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [leb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [leb_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [leb_pkg::CHAR_W-1:0]    char_in_i,
  input  logic                          end_of_input_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [leb_pkg::CHAR_W-1:0]    char_out_o,
  output logic                          last_of_line_o,
  output logic                          truncated_o
);

  leb_pkg::op_t       push_op, head_op;
  leb_pkg::q_status_t q_stat;
  logic               push, pop;

  leb_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_in_i      (char_in_i),
    .end_of_input_i (end_of_input_i),
    .q_stat_i       (q_stat),
    .push_o         (push),
    .op_o           (push_op)
  );

  leb_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .op_i   (push_op),
    .pop_i  (pop),
    .op_o   (head_op),
    .stat_o (q_stat)
  );

  leb_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (head_op),
    .q_stat_i       (q_stat),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .char_out_o     (char_out_o),
    .last_of_line_o (last_of_line_o),
    .truncated_o    (truncated_o)
  );

endmodule

FILE: rtl/leb_front.sv
// leb_front: configuration registers and classification of incoming characters
// into edit ops pushed to the op queue. Depends on leb_pkg.
module leb_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [leb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [leb_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [leb_pkg::CHAR_W-1:0]    char_in_i,
  input  logic                          end_of_input_i,
  input  leb_pkg::q_status_t            q_stat_i,
  output logic                          push_o,
  output leb_pkg::op_t                  op_o
);

  logic [leb_pkg::CHAR_W-1:0] erase_q, kill_q, end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      erase_q <= leb_pkg::ERASE_RST;
      kill_q  <= leb_pkg::KILL_RST;
      end_q   <= leb_pkg::END_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        leb_pkg::CFG_ERASE: erase_q <= cfg_data_i;
        leb_pkg::CFG_KILL:  kill_q  <= cfg_data_i;
        leb_pkg::CFG_END:   end_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // end code wins over erase, erase over kill
  always_comb begin
    op_o.ch = char_in_i;
    if (end_of_input_i || char_in_i == end_q) begin
      op_o.kind = leb_pkg::OP_FLUSH;
    end else if (char_in_i == erase_q) begin
      op_o.kind = leb_pkg::OP_ERASE;
    end else if (char_in_i == kill_q) begin
      op_o.kind = leb_pkg::OP_KILL;
    end else begin
      op_o.kind = leb_pkg::OP_APPEND;
    end
  end

  assign in_stall_o = q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;

endmodule

FILE: rtl/leb_queue.sv
// leb_queue: short fifo of classified ops between front and back.
// Depends on leb_pkg.
module leb_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  leb_pkg::op_t       op_i,
  input  logic               pop_i,
  output leb_pkg::op_t       op_o,
  output leb_pkg::q_status_t stat_o
);

  leb_pkg::op_t                entry_q [leb_pkg::QUEUE_DEPTH];
  logic [leb_pkg::QPTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [leb_pkg::QCNT_W-1:0]  count_q, count_d;
  logic                        do_push, do_pop;

  assign stat_o.full  = (count_q == leb_pkg::QCNT_W'(leb_pkg::QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign op_o         = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + leb_pkg::QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + leb_pkg::QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + leb_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - leb_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

FILE: rtl/leb_back.sv
// leb_back: line store, fill count and drain pipeline (memory read stage plus
// output register). Pops ops from leb_queue. Depends on leb_pkg.
module leb_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  leb_pkg::op_t               op_i,
  input  leb_pkg::q_status_t         q_stat_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [leb_pkg::CHAR_W-1:0] char_out_o,
  output logic                       last_of_line_o,
  output logic                       truncated_o
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_e;

  state_e                     state_q, state_d;
  logic [leb_pkg::CNT_W-1:0]  fill_q, fill_d;
  logic                       ovf_q, ovf_d;
  logic [leb_pkg::IDX_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic                       rvalid_q, rvalid_d;
  logic                       out_valid_q, out_valid_d;
  logic [leb_pkg::CHAR_W-1:0] rdata_q, out_char_q;
  logic                       rlast_q, rtrunc_q, out_last_q, out_trunc_q;
  logic                       load_out, issue, last_issue, has_room, do_append;

  logic [leb_pkg::CHAR_W-1:0] mem_q [leb_pkg::LINE_DEPTH];

  assign has_room   = (fill_q < leb_pkg::CNT_W'(leb_pkg::LINE_DEPTH));
  assign pop_o      = (state_q == ST_IDLE) && !q_stat_i.empty;
  assign do_append  = pop_o && (op_i.kind == leb_pkg::OP_APPEND) && has_room;
  assign load_out   = rvalid_q && (!out_valid_q || !out_stall_i);
  assign issue      = (state_q == ST_DRAIN) && (!rvalid_q || load_out);
  assign last_issue = issue && ({1'b0, rd_ptr_q} == fill_q - leb_pkg::CNT_W'(1));

  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    ovf_d    = ovf_q;
    rd_ptr_d = rd_ptr_q;
    unique case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          case (op_i.kind)
            leb_pkg::OP_APPEND: begin
              if (has_room) fill_d = fill_q + leb_pkg::CNT_W'(1);
              else          ovf_d  = 1'b1;
            end
            leb_pkg::OP_ERASE: begin
              if (fill_q != '0) fill_d = fill_q - leb_pkg::CNT_W'(1);
            end
            leb_pkg::OP_KILL: begin
              fill_d = '0;
              ovf_d  = 1'b0;
            end
            default: begin
              // empty line flushes nothing
              if (fill_q == '0) begin
                ovf_d = 1'b0;
              end else begin
                state_d  = ST_DRAIN;
                rd_ptr_d = '0;
              end
            end
          endcase
        end
      end
      ST_DRAIN: begin
        if (issue) rd_ptr_d = rd_ptr_q + leb_pkg::IDX_W'(1);
        if (last_issue) begin
          state_d = ST_IDLE;
          fill_d  = '0;
          ovf_d   = 1'b0;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign rvalid_d    = issue || (rvalid_q && !load_out);
  assign out_valid_d = load_out || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      ovf_q       <= 1'b0;
      rd_ptr_q    <= '0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      ovf_q       <= ovf_d;
      rd_ptr_q    <= rd_ptr_d;
      rvalid_q    <= rvalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_append) begin
      mem_q[fill_q[leb_pkg::IDX_W-1:0]] <= op_i.ch;
    end
    if (issue) begin
      rdata_q  <= mem_q[rd_ptr_q];
      rlast_q  <= last_issue;
      rtrunc_q <= last_issue && ovf_q;
    end
    if (load_out) begin
      out_char_q  <= rdata_q;
      out_last_q  <= rlast_q;
      out_trunc_q <= rtrunc_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign char_out_o     = out_char_q;
  assign last_of_line_o = out_last_q;
  assign truncated_o    = out_trunc_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= leb_pkg::CNT_W'(leb_pkg::LINE_DEPTH))
    else $error("fill count beyond line depth");

  a_drain_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> ({1'b0, rd_ptr_q} < fill_q))
    else $error("drain read pointer past fill count");

  a_no_pop_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == ST_IDLE))
    else $error("op popped while draining");

  a_read_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rvalid_q && !load_out) |=> (rvalid_q && $stable(rdata_q)))
    else $error("read data lost before output load");

  a_last_ends_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_issue |=> (state_q == ST_IDLE) && (fill_q == '0) && !ovf_q)
    else $error("line state not cleared after last read");

endmodule
